FILE: rtl/ppvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppvg_pkg
// Shared types, codes and constant functions of the polygon vertex generator.
// ----------------------------------------------------------------------------
package ppvg_pkg;

  localparam int FRAGMENTS_DEF = 10;
  localparam int FRAGMENTS_MAX = 15;
  localparam int MAX_OUT       = 10;
  localparam int PT_W          = $clog2(FRAGMENTS_MAX + 1);
  localparam int CNT_W         = $clog2(MAX_OUT);
  localparam int COORD_W       = 32;
  localparam int MAG_W         = 15;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Request kinds
  localparam logic [1:0] REQ_CUBE     = 2'd0;
  localparam logic [1:0] REQ_SPHERE   = 2'd1;
  localparam logic [1:0] REQ_CYLINDER = 2'd2;

  localparam logic [4:0] CUBE_LAST_FACE = 5'd5;

  typedef enum logic [2:0] {
    MODE_EMPTY,
    MODE_CUBE,
    MODE_SIDE_EVEN,
    MODE_SIDE_ODD,
    MODE_CAP_BOT,
    MODE_CAP_TOP
  } mode_t;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic                       centered;
    logic signed [COORD_W-1:0]  size_x;
    logic signed [COORD_W-1:0]  size_y;
    logic signed [COORD_W-1:0]  size_z;
    logic signed [COORD_W-1:0]  height;
    logic signed [COORD_W-1:0]  radius_bottom;
    logic signed [COORD_W-1:0]  radius_top;
    logic [4:0]                 poly_number;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  vertex_x;
    logic signed [COORD_W-1:0]  vertex_y;
    logic signed [COORD_W-1:0]  vertex_z;
    logic                       has_vertex;
    logic                       last_vertex;
  } res_t;

  // One vertex on its way down the pipeline; for ring points x carries the radius.
  typedef struct packed {
    logic                       valid;
    logic                       has;
    logic                       last;
    logic                       cyl;
    logic [PT_W-1:0]            pt;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } vtx_t;

  typedef struct packed {
    logic               cos_neg;
    logic [MAG_W-1:0]   cos_mag;
    logic               sin_neg;
    logic [MAG_W-1:0]   sin_mag;
  } trig_t;

  // Cube corners, bits {x, y, z}: 1 picks the high corner on that axis.
  localparam logic [2:0] FACE_TAB [6][4] = '{
    '{3'b001, 3'b101, 3'b111, 3'b011},
    '{3'b010, 3'b110, 3'b100, 3'b000},
    '{3'b000, 3'b100, 3'b101, 3'b001},
    '{3'b100, 3'b110, 3'b111, 3'b101},
    '{3'b110, 3'b010, 3'b011, 3'b111},
    '{3'b010, 3'b000, 3'b001, 3'b011}
  };

  function automatic logic [63:0] sin_term(input logic [63:0] v, input int k);
    case (k)
      1:       sin_term = v / 64'd6;
      2:       sin_term = v / 64'd20;
      3:       sin_term = v / 64'd42;
      4:       sin_term = v / 64'd72;
      5:       sin_term = v / 64'd110;
      6:       sin_term = v / 64'd156;
      7:       sin_term = v / 64'd210;
      default: sin_term = v / 64'd272;
    endcase
  endfunction

  function automatic logic [63:0] cos_term(input logic [63:0] v, input int k);
    case (k)
      1:       cos_term = v / 64'd2;
      2:       cos_term = v / 64'd12;
      3:       cos_term = v / 64'd30;
      4:       cos_term = v / 64'd56;
      5:       cos_term = v / 64'd90;
      6:       cos_term = v / 64'd132;
      7:       cos_term = v / 64'd182;
      default: cos_term = v / 64'd240;
    endcase
  endfunction

  // Clamp to [0, 1.0] in Q30, round half up to Q0.15, saturate.
  function automatic logic [MAG_W-1:0] to_q15(input longint v);
    longint      w;
    logic [63:0] q;
    w = v;
    if (w < 0) w = 0;
    if (w > longint'(ONE_Q30)) w = longint'(ONE_Q30);
    q = (64'(w) + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return q[MAG_W-1:0];
  endfunction

  // Returns {sin, cos} magnitudes of a first-quadrant angle given in Q30.
  function automatic logic [2*MAG_W-1:0] sin_cos_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      ss;
    longint      cc;
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    ss = longint'(x);
    cc = longint'(ONE_Q30);
    for (int k = 1; k <= 8; k++) begin
      ts = sin_term((ts * x2) >> 30, k);
      tc = cos_term((tc * x2) >> 30, k);
      if ((k & 1) != 0) begin
        ss = ss - longint'(ts);
        cc = cc - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cc = cc + longint'(tc);
      end
    end
    return {to_q15(ss), to_q15(cc)};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ppvg_circle_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppvg_circle_rom
// Unit circle table, one point per fragment, as sign and Q0.15 magnitude.
// ----------------------------------------------------------------------------
module ppvg_circle_rom
  import ppvg_pkg::*;
#(
  parameter int FRAGMENTS = FRAGMENTS_DEF
) (
  input  wire logic [PT_W-1:0] pt,
  output trig_t                trig
);

  localparam int IDX_W = $clog2(FRAGMENTS);

  trig_t tab [FRAGMENTS];

  for (genvar gi = 0; gi < FRAGMENTS; gi++) begin : g_point
    localparam logic [63:0] QD = 64'(4 * gi) / FRAGMENTS;
    localparam logic [63:0] RD = 64'(4 * gi) - QD * FRAGMENTS;
    localparam logic [63:0] XD = (PI_HALF_Q30 * RD + FRAGMENTS / 2) / FRAGMENTS;
    localparam logic [2*MAG_W-1:0] SC = sin_cos_q15(XD);
    localparam logic [MAG_W-1:0] SQ = SC[2*MAG_W-1:MAG_W];
    localparam logic [MAG_W-1:0] CQ = SC[MAG_W-1:0];
    localparam trig_t ENTRY = '{
      cos_neg: (QD == 64'd1) || (QD == 64'd2),
      cos_mag: QD[0] ? SQ : CQ,
      sin_neg: (QD >= 64'd2),
      sin_mag: QD[0] ? CQ : SQ
    };
    assign tab[gi] = ENTRY;
  end

  assign trig = (pt < PT_W'(FRAGMENTS)) ? tab[pt[IDX_W-1:0]] : '0;

endmodule
`default_nettype wire

FILE: rtl/ppvg_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppvg_seq
// Request decode and vertex sequencer: one vertex descriptor per cycle.
// ----------------------------------------------------------------------------
module ppvg_seq
  import ppvg_pkg::*;
#(
  parameter int FRAGMENTS = FRAGMENTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  req_t      req,
  output logic      busy,
  output vtx_t      iss
);

  localparam int CAP_N = (FRAGMENTS < MAX_OUT) ? FRAGMENTS : MAX_OUT;

  logic                       active;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           last_idx;
  mode_t                      mode;
  logic [2:0]                 face;
  logic signed [COORD_W-1:0]  lo [3];
  logic signed [COORD_W-1:0]  hi [3];
  logic signed [COORD_W-1:0]  z1;
  logic signed [COORD_W-1:0]  z2;
  logic signed [COORD_W-1:0]  r1;
  logic signed [COORD_W-1:0]  r2;
  logic [PT_W-1:0]            pi;
  logic [PT_W-1:0]            pj;

  mode_t                      mode_next;
  logic [CNT_W-1:0]           last_idx_next;
  logic [PT_W-1:0]            pi_next;
  logic [PT_W-1:0]            pj_next;
  logic                       cube_ok;
  logic                       cyl_ok;
  logic [5:0]                 pn;
  logic                       accept;
  logic [2:0]                 corner;

  assign accept = start && !busy;
  assign busy   = active && (cnt != last_idx);
  assign pn     = {1'b0, req.poly_number};

  always_comb begin
    cube_ok = (req.size_x > 0) && (req.size_y > 0) && (req.size_z > 0) &&
              (req.poly_number <= CUBE_LAST_FACE);
    cyl_ok  = (req.height > 0) && (req.radius_bottom >= 0) && (req.radius_top >= 0) &&
              ((req.radius_bottom != 0) || (req.radius_top != 0));
    pi_next = PT_W'(req.poly_number >> 1);
    pj_next = (pi_next == PT_W'(FRAGMENTS - 1)) ? '0 : pi_next + 1'b1;
    mode_next     = MODE_EMPTY;
    last_idx_next = '0;
    case (req.req_type)
      REQ_CUBE: begin
        if (cube_ok) begin
          mode_next     = MODE_CUBE;
          last_idx_next = CNT_W'(3);
        end
      end
      REQ_CYLINDER: begin
        if (cyl_ok) begin
          if (pn < 6'(2 * FRAGMENTS)) begin
            mode_next     = req.poly_number[0] ? MODE_SIDE_ODD : MODE_SIDE_EVEN;
            last_idx_next = CNT_W'(2);
          end else if ((pn == 6'(2 * FRAGMENTS)) && (req.radius_bottom != 0)) begin
            mode_next     = MODE_CAP_BOT;
            last_idx_next = CNT_W'(CAP_N - 1);
          end else if ((pn == 6'(2 * FRAGMENTS + 1)) && (req.radius_top != 0)) begin
            mode_next     = MODE_CAP_TOP;
            last_idx_next = CNT_W'(CAP_N - 1);
          end
        end
      end
      default: begin
        mode_next     = MODE_EMPTY;
        last_idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (cnt == last_idx) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Payload of the request being sequenced
  always_ff @(posedge clk) begin
    if (accept) begin
      mode     <= mode_next;
      last_idx <= last_idx_next;
      face     <= req.poly_number[2:0];
      pi       <= pi_next;
      pj       <= pj_next;
      r1       <= req.radius_bottom;
      r2       <= req.radius_top;
      lo[0]    <= req.centered ? -(req.size_x >>> 1) : '0;
      lo[1]    <= req.centered ? -(req.size_y >>> 1) : '0;
      lo[2]    <= req.centered ? -(req.size_z >>> 1) : '0;
      hi[0]    <= req.centered ? (req.size_x >>> 1) : req.size_x;
      hi[1]    <= req.centered ? (req.size_y >>> 1) : req.size_y;
      hi[2]    <= req.centered ? (req.size_z >>> 1) : req.size_z;
      z1       <= req.centered ? -(req.height >>> 1) : '0;
      z2       <= req.centered ? (req.height >>> 1) : req.height;
    end
  end

  assign corner = FACE_TAB[face][cnt[1:0]];

  always_comb begin
    iss       = '0;
    iss.valid = active;
    iss.last  = (cnt == last_idx);
    iss.has   = 1'b1;
    unique case (mode)
      MODE_CUBE: begin
        iss.x = corner[2] ? hi[0] : lo[0];
        iss.y = corner[1] ? hi[1] : lo[1];
        iss.z = corner[0] ? hi[2] : lo[2];
      end
      MODE_SIDE_EVEN: begin
        iss.cyl = 1'b1;
        case (cnt)
          CNT_W'(0): begin iss.x = r1; iss.pt = pi; iss.z = z1; end
          CNT_W'(1): begin iss.x = r2; iss.pt = pi; iss.z = z2; end
          default:   begin iss.x = r1; iss.pt = pj; iss.z = z1; end
        endcase
      end
      MODE_SIDE_ODD: begin
        iss.cyl = 1'b1;
        case (cnt)
          CNT_W'(0): begin iss.x = r2; iss.pt = pi; iss.z = z2; end
          CNT_W'(1): begin iss.x = r2; iss.pt = pj; iss.z = z2; end
          default:   begin iss.x = r1; iss.pt = pj; iss.z = z1; end
        endcase
      end
      MODE_CAP_BOT: begin
        iss.cyl = 1'b1;
        iss.x   = r1;
        iss.pt  = PT_W'(cnt);
        iss.z   = z1;
      end
      MODE_CAP_TOP: begin
        // top cap walks the ring backwards
        iss.cyl = 1'b1;
        iss.x   = r2;
        iss.pt  = PT_W'(FRAGMENTS - 1) - PT_W'(cnt);
        iss.z   = z2;
      end
      default: begin
        iss.has = 1'b0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_issues: assert property (@(posedge clk) disable iff (rst)
    accept |=> (iss.valid && (cnt == '0)))
    else $error("accepted request did not start issuing");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (cnt <= last_idx))
    else $error("vertex counter ran past the last vertex");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (iss.valid && iss.last && !accept) |=> !iss.valid)
    else $error("issue continued after the last vertex");
`endif

endmodule
`default_nettype wire

FILE: rtl/ppvg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppvg_datapath
// Ring lookup, radius scaling and output register, three stages deep.
// ----------------------------------------------------------------------------
module ppvg_datapath
  import ppvg_pkg::*;
#(
  parameter int FRAGMENTS = FRAGMENTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  vtx_t      iss,
  output logic      res_valid,
  output res_t      res
);

  localparam int PROD_W = COORD_W - 1 + MAG_W;

  trig_t               trig_lu;
  vtx_t                d2;
  trig_t               trig2;
  vtx_t                d3;
  logic                cneg3;
  logic                sneg3;
  logic [PROD_W-1:0]   prod_c;
  logic [PROD_W-1:0]   prod_s;
  logic [PROD_W-1:0]   sum_c;
  logic [PROD_W-1:0]   sum_s;
  logic [COORD_W-1:0]  mag_x;
  logic [COORD_W-1:0]  mag_y;
  logic [COORD_W-1:0]  ring_x;
  logic [COORD_W-1:0]  ring_y;

  ppvg_circle_rom #(
    .FRAGMENTS(FRAGMENTS)
  ) u_rom (
    .pt   (iss.pt),
    .trig (trig_lu)
  );

  // Stage 2: table value
  always_ff @(posedge clk) begin
    if (rst) begin
      d2 <= '0;
    end else begin
      d2 <= iss;
    end
    trig2 <= trig_lu;
  end

  // Stage 3: radius times magnitude; radius is known non-negative here
  always_ff @(posedge clk) begin
    if (rst) begin
      d3 <= '0;
    end else begin
      d3 <= d2;
    end
    cneg3  <= trig2.cos_neg;
    sneg3  <= trig2.sin_neg;
    prod_c <= PROD_W'(d2.x[COORD_W-2:0]) * PROD_W'(trig2.cos_mag);
    prod_s <= PROD_W'(d2.x[COORD_W-2:0]) * PROD_W'(trig2.sin_mag);
  end

  // Round half up at bit 15, then apply the table sign
  always_comb begin
    sum_c  = prod_c + PROD_W'(16384);
    sum_s  = prod_s + PROD_W'(16384);
    mag_x  = {1'b0, sum_c[PROD_W-1:MAG_W]};
    mag_y  = {1'b0, sum_s[PROD_W-1:MAG_W]};
    ring_x = cneg3 ? -mag_x : mag_x;
    ring_y = sneg3 ? -mag_y : mag_y;
  end

  // Stage 4: result register
  always_ff @(posedge clk) begin
    res.vertex_x    <= d3.cyl ? ring_x : d3.x;
    res.vertex_y    <= d3.cyl ? ring_y : d3.y;
    res.vertex_z    <= d3.z;
    res.has_vertex  <= d3.has;
    res.last_vertex <= d3.last;
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= d3.valid;
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    iss.valid |-> ##3 res_valid)
    else $error("issued vertex did not reach the result port");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.has_vertex) |->
      (res.last_vertex && (res.vertex_x == 0) && (res.vertex_y == 0) &&
       (res.vertex_z == 0)))
    else $error("empty result is not a zero last beat");

  a_ring_radius: assert property (@(posedge clk) disable iff (rst)
    (d2.valid && d2.cyl) |-> !d2.x[COORD_W-1])
    else $error("negative radius reached the scaler");
`endif

endmodule
`default_nettype wire

FILE: rtl/primitive_polygon_vertex_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// primitive_polygon_vertex_generator
// Emits the vertices of one cube, cylinder or empty polygon per request.
// ----------------------------------------------------------------------------
// Each vertex passes from the sequencer through the d2, d3 and result registers to res.
// Throughput: one vertex per cycle; a request holds the sequencer while its vertices
// (1, 3, 4 or min(FRAGMENTS, 10)) issue, and the next start is taken in the
// cycle that issues the last vertex, in which busy is low.
// The result side cannot stall; every beat is a single-cycle strobe on res_valid.
// Reset: synchronous rst clears the sequencer and all stage valid bits.
module primitive_polygon_vertex_generator
  import ppvg_pkg::*;
#(
  parameter int FRAGMENTS = FRAGMENTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  req_t      req,
  output logic      busy,
  output logic      res_valid,
  output res_t      res
);

  vtx_t iss;

  ppvg_seq #(
    .FRAGMENTS(FRAGMENTS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .iss   (iss)
  );

  ppvg_datapath #(
    .FRAGMENTS(FRAGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .iss       (iss),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule
`default_nettype wire
